// ===== hdl/clmc_pkg.sv =====
package clmc_pkg;

    // Lattice geometry: a power-of-two side, so toroidal wrap is plain
    // modular arithmetic on the coordinate bits.
    localparam int LATTICE_SIDE = 256;
    localparam int COORD_W      = $clog2(LATTICE_SIDE);
    localparam int ADDR_W       = 2 * COORD_W;
    localparam int CELLS        = LATTICE_SIDE * LATTICE_SIDE;

    localparam int THR_W        = 17;
    localparam int DRAW_W       = 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

    // Stream payload layout
    localparam int S_TDATA_W    = 56;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 8;

    localparam int F_ROW_LO     = 0;
    localparam int F_COL_LO     = 8;
    localparam int F_VAL_LO     = 16;
    localparam int F_SROW_LO    = 18;
    localparam int F_SCOL_LO    = 26;
    localparam int F_DRAW_LO    = 34;
    localparam int F_COIN       = 50;

    // Cell codes
    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_OCC   = 2'd1;
    localparam logic [1:0] CELL_BLOCK = 2'd2;
    localparam logic [1:0] CELL_ILLEG = 2'd3;

    // Operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ATTEMPT = 2'd2;

    // Outcome codes
    localparam logic [2:0] OUT_ACCESS      = 3'd0;
    localparam logic [2:0] OUT_ADDED       = 3'd1;
    localparam logic [2:0] OUT_ADD_REFUSED = 3'd2;
    localparam logic [2:0] OUT_REMOVED     = 3'd3;
    localparam logic [2:0] OUT_MOVED       = 3'd4;
    localparam logic [2:0] OUT_UNCHANGED   = 3'd5;
    localparam logic [2:0] OUT_BLOCKED     = 3'd6;

    // Scan order over a site and its four neighbours
    localparam logic [2:0] SCAN_CTR   = 3'd0;
    localparam logic [2:0] SCAN_UP    = 3'd1;
    localparam logic [2:0] SCAN_RIGHT = 3'd2;
    localparam logic [2:0] SCAN_DOWN  = 3'd3;
    localparam logic [2:0] SCAN_LEFT  = 3'd4;

    typedef enum logic [10:0] {
        ST_IDLE        = 11'b000_0000_0001,
        ST_SCAN_SITE   = 11'b000_0000_0010,
        ST_SITE_WAIT   = 11'b000_0000_0100,
        ST_DECIDE      = 11'b000_0000_1000,
        ST_WR_SITE     = 11'b000_0001_0000,
        ST_SCAN_SWAP   = 11'b000_0010_0000,
        ST_SWAP_WAIT   = 11'b000_0100_0000,
        ST_SWAP_DECIDE = 11'b000_1000_0000,
        ST_MV_SITE     = 11'b001_0000_0000,
        ST_MV_TGT      = 11'b010_0000_0000,
        ST_RESULT      = 11'b100_0000_0000
    } state_t;

    // Address of the cell visited at scan step k around (r, c), with wrap.
    function automatic logic [ADDR_W-1:0] scan_addr(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c,
        input logic [2:0]         k
    );
        logic [COORD_W-1:0] rr;
        logic [COORD_W-1:0] cc;
        rr = r;
        cc = c;
        case (k)
            SCAN_UP:    rr = r - COORD_W'(1);
            SCAN_RIGHT: cc = c + COORD_W'(1);
            SCAN_DOWN:  rr = r + COORD_W'(1);
            SCAN_LEFT:  cc = c - COORD_W'(1);
            default:    ;
        endcase
        return {rr, cc};
    endfunction

endpackage

// ===== hdl/constrained_lattice_mc_update.sv =====
// Write: WR_SITE, RESULT. Read: SCAN_SITE (centre only), SITE_WAIT, DECIDE, RESULT.
// Attempt: site and neighbour scan, SITE_WAIT, DECIDE, maybe WR_SITE; a swap try adds
// a target scan, SWAP_WAIT, SWAP_DECIDE, maybe MV_SITE and MV_TGT, then RESULT. The
// next request is taken once the result is registered; the lattice RAM is
// single-port, one access per cycle. rst_n (async, active low) clears control and
// sets accept_threshold to 65536; lattice contents are undefined until written.
module constrained_lattice_mc_update
    import clmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: accept_threshold
    input  logic                 cfg_we,
    input  logic [THR_W-1:0]     cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // site_row[7:0], site_col[15:8], cell_value[17:16], swap_row[25:18],
    // swap_col[33:26], accept_draw[49:34], swap_coin[50], zero fill [55:51]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cell_state[1:0], site_changed[2], swap_done[3], outcome[6:4], zero [7]
    output logic [M_TDATA_W-1:0] m_tdata
);

    // ------------------------------------------------------------------
    // Lattice RAM: single port, registered read (read-before-write).
    // ------------------------------------------------------------------
    logic [1:0]        lattice_mem [CELLS];
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [1:0]        mem_wd;
    logic [1:0]        mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice_mem[mem_addr] <= mem_wd;
        end
        mem_rdata_reg <= lattice_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [THR_W-1:0]   thr_reg;

    // latched request
    logic [1:0]         op_reg;
    logic [COORD_W-1:0] row_reg, col_reg, srow_reg, scol_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic               coin_reg;

    // scan pointer and read tracking
    logic [2:0]         cnt_reg, cnt_next;
    logic               rd_pend_reg;
    logic [2:0]         rd_idx_reg;
    logic [1:0]         ctr_val_reg;      // value of the scanned centre cell
    logic               nocc_reg;         // some neighbour of it is occupied

    // attempt bookkeeping
    logic [1:0]         before_reg, before_next;
    logic [1:0]         site_val_reg, site_val_next;
    logic [1:0]         site_wd_reg, site_wd_next;
    logic               go_swap_reg, go_swap_next;
    logic               constr_reg, constr_next;
    logic               swapped_reg, swapped_next;
    logic [2:0]         outcome_reg, outcome_next;

    // result output register
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic s_xfer;
    logic m_load;
    logic is_read;
    logic scanning;
    logic draw_accepts;
    logic site_changed;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign is_read      = (op_reg != OP_WRITE) && (op_reg != OP_ATTEMPT);
    assign scanning     = (state_reg == ST_SCAN_SITE) || (state_reg == ST_SCAN_SWAP);
    assign draw_accepts = {1'b0, draw_reg} < thr_reg;
    // only an attempt can report a change
    assign site_changed = (op_reg == OP_ATTEMPT) && (site_val_reg != before_reg);
    assign m_load       = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // RAM address / write mux
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we   = 1'b0;
        mem_wd   = site_wd_reg;
        mem_addr = {row_reg, col_reg};
        case (state_reg)
            ST_SCAN_SITE:
            begin
                mem_addr = scan_addr(row_reg, col_reg, cnt_reg);
            end
            ST_SCAN_SWAP:
            begin
                mem_addr = scan_addr(srow_reg, scol_reg, cnt_reg);
            end
            ST_WR_SITE:
            begin
                mem_we = 1'b1;
            end
            ST_MV_SITE:
            begin
                mem_we = 1'b1;
                mem_wd = CELL_EMPTY;
            end
            ST_MV_TGT:
            begin
                mem_we   = 1'b1;
                mem_wd   = CELL_OCC;
                mem_addr = {srow_reg, scol_reg};
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = '0;
        before_next   = before_reg;
        site_val_next = site_val_reg;
        site_wd_next  = site_wd_reg;
        go_swap_next  = go_swap_reg;
        constr_next   = constr_reg;
        swapped_next  = swapped_reg;
        outcome_next  = outcome_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    swapped_next = 1'b0;
                    go_swap_next = 1'b0;
                    outcome_next = OUT_ACCESS;
                    // a write of code 3 is stored as blocked
                    site_wd_next = (s_tdata[F_VAL_LO +: 2] == CELL_ILLEG) ?
                                   CELL_BLOCK : s_tdata[F_VAL_LO +: 2];
                    if (s_tuser == OP_WRITE)
                    begin
                        state_next = ST_WR_SITE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_SITE;
                    end
                end
            end

            ST_SCAN_SITE:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == SCAN_LEFT || is_read)
                begin
                    state_next = ST_SITE_WAIT;
                end
            end

            ST_SITE_WAIT:
            begin
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                before_next   = ctr_val_reg;
                site_val_next = ctr_val_reg;
                constr_next   = nocc_reg;
                state_next    = ST_RESULT;
                if (op_reg == OP_ATTEMPT)
                begin
                    case (ctr_val_reg)
                        CELL_BLOCK:
                        begin
                            outcome_next = OUT_BLOCKED;
                        end
                        CELL_EMPTY:
                        begin
                            if (nocc_reg)
                            begin
                                outcome_next = OUT_ADD_REFUSED;
                            end
                            else
                            begin
                                outcome_next = OUT_ADDED;
                                site_wd_next = CELL_OCC;
                                state_next   = ST_WR_SITE;
                            end
                        end
                        default:
                        begin
                            // occupied site
                            site_wd_next = CELL_EMPTY;
                            if (draw_accepts)
                            begin
                                outcome_next = OUT_REMOVED;
                                state_next   = ST_WR_SITE;
                            end
                            else if (nocc_reg)
                            begin
                                // constrained removal first, then maybe a swap
                                outcome_next = OUT_REMOVED;
                                go_swap_next = coin_reg;
                                state_next   = ST_WR_SITE;
                            end
                            else if (coin_reg)
                            begin
                                state_next = ST_SCAN_SWAP;
                            end
                            else
                            begin
                                outcome_next = OUT_UNCHANGED;
                            end
                        end
                    endcase
                end
            end

            ST_WR_SITE:
            begin
                site_val_next = site_wd_reg;
                state_next    = go_swap_reg ? ST_SCAN_SWAP : ST_RESULT;
            end

            ST_SCAN_SWAP:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == SCAN_LEFT)
                begin
                    state_next = ST_SWAP_WAIT;
                end
            end

            ST_SWAP_WAIT:
            begin
                state_next = ST_SWAP_DECIDE;
            end

            ST_SWAP_DECIDE:
            begin
                // the site itself, if emptied, is already so in the RAM
                if (ctr_val_reg == CELL_EMPTY && !nocc_reg)
                begin
                    state_next = ST_MV_SITE;
                end
                else
                begin
                    outcome_next = constr_reg ? OUT_REMOVED : OUT_UNCHANGED;
                    state_next   = ST_RESULT;
                end
            end

            ST_MV_SITE:
            begin
                site_val_next = CELL_EMPTY;
                state_next    = ST_MV_TGT;
            end

            ST_MV_TGT:
            begin
                swapped_next = 1'b1;
                outcome_next = OUT_MOVED;
                state_next   = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (m_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THR_RESET;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= scanning;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (m_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            op_reg   <= s_tuser;
            row_reg  <= s_tdata[F_ROW_LO  +: COORD_W];
            col_reg  <= s_tdata[F_COL_LO  +: COORD_W];
            srow_reg <= s_tdata[F_SROW_LO +: COORD_W];
            scol_reg <= s_tdata[F_SCOL_LO +: COORD_W];
            draw_reg <= s_tdata[F_DRAW_LO +: DRAW_W];
            coin_reg <= s_tdata[F_COIN];
        end

        before_reg   <= before_next;
        site_val_reg <= site_val_next;
        site_wd_reg  <= site_wd_next;
        go_swap_reg  <= go_swap_next;
        constr_reg   <= constr_next;
        swapped_reg  <= swapped_next;
        outcome_reg  <= outcome_next;

        // RAM data arrives in the cycle after its scan address
        rd_idx_reg <= cnt_reg;
        if (rd_pend_reg)
        begin
            if (rd_idx_reg == SCAN_CTR)
            begin
                ctr_val_reg <= mem_rdata_reg;
            end
            else if (mem_rdata_reg == CELL_OCC)
            begin
                nocc_reg <= 1'b1;
            end
        end
        if (scanning && cnt_reg == SCAN_CTR)
        begin
            nocc_reg <= 1'b0;
        end

        if (m_load)
        begin
            m_tdata_reg <= {1'b0, outcome_reg, swapped_reg, site_changed, site_val_reg};
        end
    end

endmodule
